/* rtl/core/esd_pkg.sv */
// ----------------------------------------------------------------------------
// Escape string decoder package
// Shared types, character constants and small decode functions for the
// escape string decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  // Width of the saturating byte counter.
  localparam int COUNT_BITS = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Decode modes.
  typedef enum logic [2:0] {
    MODE_GROUND = 3'd0,
    MODE_BSLASH = 3'd1,
    MODE_OCT    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_CARET  = 3'd4
  } esd_mode_t;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Character constants.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CTRL_MASK = 8'h1F;

  // One result word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] byte_count;
    logic [7:0] stop_char;
    logic       last;
  } esd_result_t;

  // Up to two results written into the output queue in one cycle.
  typedef struct packed {
    logic        push0;
    logic        push1;
    esd_result_t res0;
    esd_result_t res1;
  } esd_push_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex_digit(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) ||
           (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Value of a hex digit; letters have 1..6 in their low nibble.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c[3:0];
    end
    return 4'(c[3:0] + 4'd9);
  endfunction

  // Byte for a backslash followed by a character that is not a number.
  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    logic [7:0] b;
    case (c)
      8'h61:   b = 8'd7;   // a
      8'h62:   b = 8'd8;   // b
      8'h65:   b = 8'd27;  // e
      8'h66:   b = 8'd12;  // f
      8'h6E:   b = 8'd10;  // n
      8'h72:   b = 8'd13;  // r
      8'h74:   b = 8'd9;   // t
      8'h76:   b = 8'd11;  // v
      CH_QUEST: b = CH_DEL;
      8'h5F:   b = 8'd32;  // underscore
      default: b = c;
    endcase
    return b;
  endfunction

  // Saturating increment of the byte counter.
  function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : COUNT_BITS'(v + 1'b1);
  endfunction

  // Counter value reported on an end word, clamped to 255.
  function automatic logic [7:0] count_report(input logic [COUNT_BITS-1:0] v);
    logic [15:0] wide;
    wide = 16'(v);
    return (wide > 16'd255) ? 8'hFF : wide[7:0];
  endfunction

endpackage

/* rtl/core/esd_if.sv */
// ----------------------------------------------------------------------------
// Escape string decoder channels
// Valid/ready interfaces for the character input and the result output.
// ----------------------------------------------------------------------------
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       equals_ends;

  modport source (output valid, output in_char, output equals_ends, input ready);
  modport sink   (input valid, input in_char, input equals_ends, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] byte_count;
  logic [7:0] stop_char;
  logic       last;

  modport source (output valid, output kind, output out_byte, output byte_count,
                  output stop_char, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input byte_count,
                  input stop_char, input last, output ready);
endinterface

/* rtl/core/esd_decode.sv */
// ----------------------------------------------------------------------------
// Escape string decoder step logic
// Holds the decode mode, run value and byte counter, and turns one accepted
// character into up to two result words.
// ----------------------------------------------------------------------------
module esd_decode (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [7:0]                     in_char,
  input  logic                           equals_ends,
  output esd_pkg::esd_push_t             push
);

  esd_pkg::esd_mode_t                mode;
  esd_pkg::esd_mode_t                mode_next;
  logic [7:0]                        accum;
  logic [7:0]                        accum_next;
  logic [esd_pkg::COUNT_BITS-1:0]    emitted;
  logic [esd_pkg::COUNT_BITS-1:0]    emitted_next;

  logic                              oct_digit;
  logic                              hex_digit;
  logic                              is_x;
  logic                              term;
  logic                              flush;
  logic                              gnd;
  logic                              caret_ok;
  logic [esd_pkg::COUNT_BITS-1:0]    em_base;
  logic [esd_pkg::COUNT_BITS-1:0]    em_inc;
  esd_pkg::esd_result_t              g_res;
  logic                              g_has;
  esd_pkg::esd_result_t              res0;
  esd_pkg::esd_result_t              res1;
  logic                              push0;
  logic                              push1;

  // Character classes.
  assign oct_digit = (in_char >= esd_pkg::CH_ZERO) && (in_char <= esd_pkg::CH_SEVEN);
  assign hex_digit = esd_pkg::is_hex_digit(in_char);
  assign is_x      = (in_char == esd_pkg::CH_LOW_X) || (in_char == esd_pkg::CH_UP_X);
  assign term      = (in_char == esd_pkg::CH_COLON) || (in_char == esd_pkg::CH_NUL) ||
                     ((in_char == esd_pkg::CH_EQUALS) && equals_ends);
  assign caret_ok  = (in_char >= esd_pkg::CH_AT) && (in_char <= esd_pkg::CH_TILDE);

  // A non-digit closes an octal or hex run; the character then goes to ground.
  assign flush = ((mode == esd_pkg::MODE_OCT) && !oct_digit) ||
                 ((mode == esd_pkg::MODE_HEX) && !hex_digit);
  assign gnd   = flush || !((mode == esd_pkg::MODE_BSLASH) || (mode == esd_pkg::MODE_OCT) ||
                            (mode == esd_pkg::MODE_HEX) || (mode == esd_pkg::MODE_CARET));

  // Counter as seen by the ground character, after any flushed byte.
  assign em_base = flush ? esd_pkg::count_inc(emitted) : emitted;
  assign em_inc  = esd_pkg::count_inc(em_base);

  // Result of a character handled in ground mode.
  always_comb begin
    g_res = '0;
    g_has = 1'b0;
    if (term) begin
      g_res.kind       = esd_pkg::KIND_END;
      g_res.byte_count = esd_pkg::count_report(em_base);
      g_res.stop_char  = in_char;
      g_has            = 1'b1;
    end else if ((in_char != esd_pkg::CH_BSLASH) && (in_char != esd_pkg::CH_CARET)) begin
      g_res.kind     = esd_pkg::KIND_BYTE;
      g_res.out_byte = in_char;
      g_has          = 1'b1;
    end
  end

  // Output words for the current character.
  always_comb begin
    res0  = '0;
    res1  = '0;
    push0 = 1'b0;
    push1 = 1'b0;
    if (flush) begin
      res0.kind     = esd_pkg::KIND_BYTE;
      res0.out_byte = accum;
      push0         = 1'b1;
      if (g_has) begin
        res1      = g_res;
        res1.last = 1'b1;
        push1     = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
    end else if (gnd) begin
      res0      = g_res;
      res0.last = 1'b1;
      push0     = g_has;
    end else begin
      unique case (mode)
        esd_pkg::MODE_BSLASH: begin
          if (in_char == esd_pkg::CH_NUL) begin
            res0.kind = esd_pkg::KIND_ERROR;
            push0     = 1'b1;
          end else if (!oct_digit && !is_x) begin
            res0.kind     = esd_pkg::KIND_BYTE;
            res0.out_byte = esd_pkg::escape_byte(in_char);
            push0         = 1'b1;
          end
        end
        esd_pkg::MODE_CARET: begin
          push0 = 1'b1;
          if (caret_ok) begin
            res0.kind     = esd_pkg::KIND_BYTE;
            res0.out_byte = in_char & esd_pkg::CTRL_MASK;
          end else if (in_char == esd_pkg::CH_QUEST) begin
            res0.kind     = esd_pkg::KIND_BYTE;
            res0.out_byte = esd_pkg::CH_DEL;
          end else begin
            res0.kind = esd_pkg::KIND_ERROR;
          end
        end
        default: begin
          // Digits that extend a run give no word.
        end
      endcase
      res0.last = 1'b1;
    end
  end

  assign push.push0 = push0 && accept;
  assign push.push1 = push1 && accept;
  assign push.res0  = res0;
  assign push.res1  = res1;

  // Next mode, run value and counter.
  always_comb begin
    mode_next    = mode;
    accum_next   = accum;
    emitted_next = emitted;
    if (gnd) begin
      mode_next  = esd_pkg::MODE_GROUND;
      accum_next = '0;
      if (term) begin
        emitted_next = '0;
      end else if (in_char == esd_pkg::CH_BSLASH) begin
        mode_next    = esd_pkg::MODE_BSLASH;
        emitted_next = em_base;
      end else if (in_char == esd_pkg::CH_CARET) begin
        mode_next    = esd_pkg::MODE_CARET;
        emitted_next = em_base;
      end else begin
        emitted_next = em_inc;
      end
    end else begin
      unique case (mode)
        esd_pkg::MODE_BSLASH: begin
          mode_next = esd_pkg::MODE_GROUND;
          if (oct_digit) begin
            mode_next  = esd_pkg::MODE_OCT;
            accum_next = {5'd0, in_char[2:0]};
          end else if (is_x) begin
            mode_next  = esd_pkg::MODE_HEX;
            accum_next = '0;
          end else if (in_char == esd_pkg::CH_NUL) begin
            accum_next   = '0;
            emitted_next = '0;
          end else begin
            emitted_next = em_inc;
          end
        end
        esd_pkg::MODE_OCT: begin
          accum_next = {accum[4:0], in_char[2:0]};
        end
        esd_pkg::MODE_HEX: begin
          accum_next = {accum[3:0], esd_pkg::hex_value(in_char)};
        end
        esd_pkg::MODE_CARET: begin
          mode_next = esd_pkg::MODE_GROUND;
          if (caret_ok || (in_char == esd_pkg::CH_QUEST)) begin
            emitted_next = em_inc;
          end else begin
            accum_next   = '0;
            emitted_next = '0;
          end
        end
        default: begin
          mode_next = esd_pkg::MODE_GROUND;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= esd_pkg::MODE_GROUND;
      accum   <= '0;
      emitted <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      accum   <= accum_next;
      emitted <= emitted_next;
    end
  end

`ifndef ASSERT_OFF
  // An end or error word always returns the decoder to ground with a clear counter.
  a_finish_ground: assert property (@(posedge clk) disable iff (rst)
    (push.push0 && !push.push1 && (push.res0.kind != esd_pkg::KIND_BYTE)) |=>
      ((mode == esd_pkg::MODE_GROUND) && (emitted == '0)))
    else $error("decoder not in ground after end or error");

  // A second word only follows a flushed run byte.
  a_pair_flush: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> (push.push0 && (push.res0.kind == esd_pkg::KIND_BYTE) && !push.res0.last))
    else $error("second word without flushed byte");

  // Run value is zero whenever the decoder sits in ground.
  a_ground_accum: assert property (@(posedge clk) disable iff (rst)
    (mode == esd_pkg::MODE_GROUND) |-> (accum == '0))
    else $error("run value not cleared in ground");
`endif

endmodule

/* rtl/core/esd_queue.sv */
// ----------------------------------------------------------------------------
// Escape string decoder result queue
// Four-entry queue that takes up to two result words a cycle and hands one
// word a cycle to the output channel while that channel is ready.
// ----------------------------------------------------------------------------
module esd_queue (
  input  logic               clk,
  input  logic               rst,
  input  esd_pkg::esd_push_t push,
  output logic               space,
  esd_out_if.source          results
);

  localparam int DEPTH    = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  esd_pkg::esd_result_t  mem [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic                  pop;
  esd_pkg::esd_result_t  head;

  assign pop   = results.valid && results.ready;
  assign space = (count <= CNT_BITS'(DEPTH - 2));

  // Occupancy after this cycle's writes and read.
  assign count_next = count + CNT_BITS'(push.push0) + CNT_BITS'(push.push1) -
                      CNT_BITS'(pop);

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.push0) + PTR_BITS'(push.push1);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count_next;
    end
  end

  // Entry storage; the second word goes in the slot after the first.
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.push1) begin
      mem[PTR_BITS'(wr_ptr + 1'b1)] <= push.res1;
    end
  end

  // Head word drives the output channel.
  assign head               = mem[rd_ptr];
  assign results.valid      = (count != '0);
  assign results.kind       = head.kind;
  assign results.out_byte   = head.out_byte;
  assign results.byte_count = head.byte_count;
  assign results.stop_char  = head.stop_char;
  assign results.last       = head.last;

`ifndef ASSERT_OFF
  // Occupancy never exceeds the queue depth.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("result queue overflow");

  // Words are only written when two slots were free.
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    push.push0 |-> space)
    else $error("result written without room");

  // Pointer distance agrees with occupancy.
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count != CNT_BITS'(DEPTH)) |-> (PTR_BITS'(wr_ptr - rd_ptr) == count[PTR_BITS-1:0]))
    else $error("queue pointers and count disagree");
`endif

endmodule

/* rtl/core/escape_string_decoder.sv */
// ----------------------------------------------------------------------------
// Escape string decoder
// Decodes a character stream with backslash and caret escapes into bytes,
// end words and error words, one character per cycle.
// ----------------------------------------------------------------------------
// Result words are registered in the result queue before they reach the output.
// Throughput: one character per cycle while the queue has room; the four-entry
// result queue drains one word per cycle when the output is ready, and input
// stalls whenever fewer than two queue slots are free.
// Reset: synchronous rst returns the decoder to ground and empties the queue.
module escape_string_decoder (
  input  logic      clk,
  input  logic      rst,
  esd_in_if.sink    chars,
  esd_out_if.source results
);

  esd_pkg::esd_push_t push;
  logic               space;
  logic               accept;

  // Characters are taken whenever the queue can absorb two words.
  assign chars.ready = space;
  assign accept      = chars.valid && space;

  esd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_char     (chars.in_char),
    .equals_ends (chars.equals_ends),
    .push        (push)
  );

  esd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .space   (space),
    .results (results)
  );

endmodule

/* bench/escape_string_decoder_tb.sv */
// ----------------------------------------------------------------------------
// Escape string decoder testbench
// Drives character words through the input channel and checks every result
// word against a cycle-free decoder model in the bench or a hand-written result.
// A short table of directed characters covers the extremes and the corner cases.
// Random strings follow: well-formed escapes with random content, with some
// noise and malformed escapes mixed in. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module escape_string_decoder_tb;

  // One character word to send, with an optional hand-written expectation.
  typedef struct {
    logic [7:0]           ch;
    logic                 eq;
    logic                 typed;
    esd_pkg::esd_result_t want;
  } char_item_t;

  localparam int NUM_ROWS     = 27;
  localparam int RANDOM_ITEMS = 1420;
  localparam int CALM_ITEMS   = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  esd_in_if  chars ();
  esd_out_if results ();

  escape_string_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Directed characters; hand-written results only where they are obvious.
  char_item_t directed_rows [NUM_ROWS] = '{
    '{8'h41,              1'b0, 1'b1, '{esd_pkg::KIND_BYTE,  8'h41, 8'd0, 8'd0, 1'b1}},
    '{8'hFF,              1'b0, 1'b1, '{esd_pkg::KIND_BYTE,  8'hFF, 8'd0, 8'd0, 1'b1}},
    '{esd_pkg::CH_COLON,  1'b0, 1'b1,
      '{esd_pkg::KIND_END, 8'h00, 8'd2, esd_pkg::CH_COLON, 1'b1}},
    '{esd_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
    '{"n",                1'b0, 1'b0, '0},
    '{esd_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
    '{"3",                1'b0, 1'b0, '0},
    '{esd_pkg::CH_SEVEN,  1'b0, 1'b0, '0},
    '{esd_pkg::CH_SEVEN,  1'b1, 1'b0, '0},
    '{esd_pkg::CH_EQUALS, 1'b1, 1'b0, '0},
    '{esd_pkg::CH_EQUALS, 1'b0, 1'b0, '0},
    '{esd_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
    '{esd_pkg::CH_LOW_X,  1'b0, 1'b0, '0},
    '{"g",                1'b0, 1'b0, '0},
    '{esd_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
    '{esd_pkg::CH_UP_X,   1'b0, 1'b0, '0},
    '{"f",                1'b0, 1'b0, '0},
    '{"F",                1'b0, 1'b0, '0},
    '{esd_pkg::CH_NUL,    1'b0, 1'b0, '0},
    '{esd_pkg::CH_BSLASH, 1'b0, 1'b0, '0},
    '{esd_pkg::CH_NUL,    1'b1, 1'b1, '{esd_pkg::KIND_ERROR, 8'h00, 8'd0, 8'd0, 1'b1}},
    '{esd_pkg::CH_CARET,  1'b0, 1'b0, '0},
    '{esd_pkg::CH_QUEST,  1'b0, 1'b0, '0},
    '{esd_pkg::CH_CARET,  1'b0, 1'b0, '0},
    '{esd_pkg::CH_AT,     1'b0, 1'b1, '{esd_pkg::KIND_BYTE,  8'h00, 8'd0, 8'd0, 1'b1}},
    '{esd_pkg::CH_CARET,  1'b1, 1'b0, '0},
    '{8'h80,              1'b0, 1'b1, '{esd_pkg::KIND_ERROR, 8'h00, 8'd0, 8'd0, 1'b1}}
  };

  // Decoder state of the bench model.
  esd_pkg::esd_mode_t             dec_mode    = esd_pkg::MODE_GROUND;
  logic [7:0]                     dec_accum   = '0;
  logic [esd_pkg::COUNT_BITS-1:0] dec_emitted = '0;

  // Words produced by the character being decoded.
  esd_pkg::esd_result_t step_res [2];
  int                   step_n;

  char_item_t           sent_q [$];
  esd_pkg::esd_result_t want_q [$];
  int                   errors;
  int                   sent_total;
  bit                   idle_on;
  int                   stall_left;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  task automatic put_word(input logic [1:0] kind, input logic [7:0] b,
                          input logic [7:0] cnt, input logic [7:0] stop);
    step_res[step_n] = '{kind, b, cnt, stop, 1'b0};
    step_n++;
  endtask

  task automatic emit_byte(input logic [7:0] b);
    put_word(esd_pkg::KIND_BYTE, b, 8'd0, 8'd0);
    if (dec_emitted != esd_pkg::COUNT_MAX) begin
      dec_emitted++;
    end
  endtask

  // End or error word; either way the next string starts from scratch.
  task automatic close_string(input logic [1:0] kind, input logic [7:0] stop);
    logic [7:0] cnt;
    cnt = (int'(dec_emitted) > 255) ? 8'hFF : 8'(dec_emitted);
    if (kind == esd_pkg::KIND_END) begin
      put_word(esd_pkg::KIND_END, 8'd0, cnt, stop);
    end else begin
      put_word(esd_pkg::KIND_ERROR, 8'd0, 8'd0, 8'd0);
    end
    dec_mode    = esd_pkg::MODE_GROUND;
    dec_accum   = '0;
    dec_emitted = '0;
  endtask

  task automatic ground_char(input logic [7:0] c, input logic eq);
    if (c == esd_pkg::CH_COLON || c == esd_pkg::CH_NUL ||
        (c == esd_pkg::CH_EQUALS && eq)) begin
      close_string(esd_pkg::KIND_END, c);
    end else if (c == esd_pkg::CH_BSLASH) begin
      dec_mode = esd_pkg::MODE_BSLASH;
    end else if (c == esd_pkg::CH_CARET) begin
      dec_mode = esd_pkg::MODE_CARET;
    end else begin
      emit_byte(c);
    end
  endtask

  // Nibble value of a hex digit, or -1 for any other character.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic eq);
    int         nib;
    logic [7:0] b;
    step_n = 0;
    case (dec_mode)
      esd_pkg::MODE_BSLASH: begin
        dec_mode = esd_pkg::MODE_GROUND;
        if (c >= "0" && c <= "7") begin
          dec_mode  = esd_pkg::MODE_OCT;
          dec_accum = c - 8'h30;
        end else if (c == esd_pkg::CH_LOW_X || c == esd_pkg::CH_UP_X) begin
          dec_mode  = esd_pkg::MODE_HEX;
          dec_accum = '0;
        end else if (c == esd_pkg::CH_NUL) begin
          close_string(esd_pkg::KIND_ERROR, 8'd0);
        end else begin
          case (c)
            "a":     b = 8'd7;
            "b":     b = 8'd8;
            "e":     b = 8'd27;
            "f":     b = 8'd12;
            "n":     b = 8'd10;
            "r":     b = 8'd13;
            "t":     b = 8'd9;
            "v":     b = 8'd11;
            "?":     b = 8'd127;
            "_":     b = 8'd32;
            default: b = c;
          endcase
          emit_byte(b);
        end
      end
      esd_pkg::MODE_OCT: begin
        if (c >= "0" && c <= "7") begin
          dec_accum = {dec_accum[4:0], 3'b000} + (c - 8'h30);
        end else begin
          dec_mode = esd_pkg::MODE_GROUND;
          emit_byte(dec_accum);
          dec_accum = '0;
          ground_char(c, eq);
        end
      end
      esd_pkg::MODE_HEX: begin
        nib = hex_nibble(c);
        if (nib >= 0) begin
          dec_accum = {dec_accum[3:0], 4'(nib)};
        end else begin
          dec_mode = esd_pkg::MODE_GROUND;
          emit_byte(dec_accum);
          dec_accum = '0;
          ground_char(c, eq);
        end
      end
      esd_pkg::MODE_CARET: begin
        dec_mode = esd_pkg::MODE_GROUND;
        if (c >= "@" && c <= "~") begin
          emit_byte(c & 8'h1F);
        end else if (c == esd_pkg::CH_QUEST) begin
          emit_byte(8'd127);
        end else begin
          close_string(esd_pkg::KIND_ERROR, 8'd0);
        end
      end
      default: begin
        dec_mode = esd_pkg::MODE_GROUND;
        ground_char(c, eq);
      end
    endcase
    if (step_n > 0) begin
      step_res[step_n-1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted characters, check accepted result words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    char_item_t           it;
    esd_pkg::esd_result_t got;
    esd_pkg::esd_result_t exp;
    if (!rst) begin
      if (chars.valid && chars.ready) begin
        it = sent_q.pop_front();
        decode_char(chars.in_char, chars.equals_ends);
        if (it.typed) begin
          want_q.push_back(it.want);
        end else begin
          for (int i = 0; i < step_n; i++) begin
            want_q.push_back(step_res[i]);
          end
        end
      end
      if (results.valid && results.ready) begin
        got = '{results.kind, results.out_byte, results.byte_count,
                results.stop_char, results.last};
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected word: kind=%0d byte=%h count=%0d stop=%h last=%b",
                     got.kind, got.out_byte, got.byte_count, got.stop_char, got.last);
          end
        end else begin
          exp = want_q.pop_front();
          if (got.kind !== exp.kind || got.out_byte !== exp.out_byte ||
              got.byte_count !== exp.byte_count || got.stop_char !== exp.stop_char ||
              got.last !== exp.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected kind=%0d byte=%h count=%0d stop=%h last=%b",
                       exp.kind, exp.out_byte, exp.byte_count, exp.stop_char, exp.last);
              $display("          actual   kind=%0d byte=%h count=%0d stop=%h last=%b",
                       got.kind, got.out_byte, got.byte_count, got.stop_char, got.last);
            end
          end
        end
      end
    end
  end

  // Result side backpressure in bursts.
  always @(posedge clk) begin
    if (rst) begin
      stall_left    <= 0;
      results.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      results.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 5);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one word and hold it until the decoder takes it.
  task automatic send_item(input char_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      chars.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    sent_q.push_back(it);
    chars.valid       <= 1'b1;
    chars.in_char     <= it.ch;
    chars.equals_ends <= it.eq;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    sent_total++;
  endtask

  task automatic send_char(input logic [7:0] c, input logic eq);
    char_item_t it;
    it = '{c, eq, 1'b0, '0};
    send_item(it);
  endtask

  // Any character that stays a plain byte in ground mode.
  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == esd_pkg::CH_COLON || c == esd_pkg::CH_BSLASH ||
               c == esd_pkg::CH_CARET);
    return c;
  endfunction

  task automatic send_plain();
    logic [7:0] c;
    c = pick_plain();
    send_char(c, (c == esd_pkg::CH_EQUALS) ? 1'b0 : 1'($urandom_range(0, 1)));
  endtask

  // A well-formed string of random escapes closed by a random terminator.
  task automatic random_string();
    logic [7:0] named [10] = '{"a", "b", "e", "f", "n", "r", "t", "v", "?", "_"};
    logic [7:0] hex_chars [22] = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
                                  "a", "b", "c", "d", "e", "f",
                                  "A", "B", "C", "D", "E", "F"};
    logic [7:0] c;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 5))
        0, 1: send_plain();
        2: begin
          send_char(esd_pkg::CH_BSLASH, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 1) == 0) begin
            c = named[$urandom_range(0, 9)];
          end else begin
            do begin
              c = 8'($urandom_range(1, 255));
            end while ((c >= "0" && c <= "7") || c == esd_pkg::CH_LOW_X ||
                       c == esd_pkg::CH_UP_X);
          end
          send_char(c, 1'($urandom_range(0, 1)));
        end
        3: begin
          send_char(esd_pkg::CH_BSLASH, 1'($urandom_range(0, 1)));
          repeat ($urandom_range(1, 5)) send_char(8'($urandom_range(8'h30, 8'h37)), 1'b1);
        end
        4: begin
          send_char(esd_pkg::CH_BSLASH, 1'b0);
          send_char(($urandom_range(0, 1) == 0) ? esd_pkg::CH_LOW_X : esd_pkg::CH_UP_X,
                    1'b0);
          repeat ($urandom_range(0, 4)) send_char(hex_chars[$urandom_range(0, 21)], 1'b1);
        end
        default: begin
          send_char(esd_pkg::CH_CARET, 1'($urandom_range(0, 1)));
          c = ($urandom_range(0, 7) == 0) ? esd_pkg::CH_QUEST :
                                             8'($urandom_range(8'h40, 8'h7E));
          send_char(c, 1'($urandom_range(0, 1)));
        end
      endcase
    end
    case ($urandom_range(0, 2))
      0:       send_char(esd_pkg::CH_COLON, 1'($urandom_range(0, 1)));
      1:       send_char(esd_pkg::CH_NUL, 1'($urandom_range(0, 1)));
      default: send_char(esd_pkg::CH_EQUALS, 1'b1);
    endcase
  endtask

  // Malformed escapes: backslash then NUL, or a caret before a bad character.
  task automatic broken_escape();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      send_char(esd_pkg::CH_BSLASH, 1'($urandom_range(0, 1)));
      send_char(esd_pkg::CH_NUL, 1'($urandom_range(0, 1)));
    end else begin
      send_char(esd_pkg::CH_CARET, 1'($urandom_range(0, 1)));
      do begin
        c = 8'($urandom_range(0, 255));
      end while ((c >= esd_pkg::CH_AT && c <= esd_pkg::CH_TILDE) ||
                 c == esd_pkg::CH_QUEST);
      send_char(c, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int limit;
    errors     = 0;
    sent_total = 0;
    idle_on    = 1'b1;
    chars.valid       <= 1'b0;
    chars.in_char     <= 8'd0;
    chars.equals_ends <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(directed_rows[i]);
    end

    // One long string so the byte counter saturates.
    repeat (270) send_plain();
    send_char(esd_pkg::CH_COLON, 1'b0);

    // Random strings with noise and malformed escapes; calm at the end.
    limit = NUM_ROWS + RANDOM_ITEMS;
    while (sent_total < limit) begin
      if (sent_total % 120 < 4) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (sent_total > limit - CALM_ITEMS) begin
        idle_on = 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       repeat ($urandom_range(1, 10))
                   send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1:       broken_escape();
        default: random_string();
      endcase
    end
    // Close any escape left open by noise so its words come out.
    send_char(esd_pkg::CH_COLON, 1'b0);
    chars.valid <= 1'b0;

    while (sent_q.size() != 0 || want_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
